/* sv/lbp_pkg.sv */
package lbp_pkg;

  // Geometry limits of the line stores and the frame.
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);

  // Width of the geometry registers and of the configuration data.
  localparam int DIM_W = 12;
  localparam int THR_W = 8;
  localparam int PIX_W = 8;
  localparam int CFG_W = DIM_W;

  // Results per input pixel at most.
  localparam int NSLOT = 4;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_IMAGE_WIDTH        = 2'd0,
    CFG_IMAGE_HEIGHT       = 2'd1,
    CFG_BINARIZE_THRESHOLD = 2'd2
  } cfg_idx_t;

  // Reset values of the configuration registers.
  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(1280);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(720);
  localparam logic [THR_W-1:0] THRESH_RESET = THR_W'(150);

  // Row places inside one window column.
  localparam logic [1:0] ROW_TOP = 2'd0;
  localparam logic [1:0] ROW_MID = 2'd1;
  localparam logic [1:0] ROW_BOT = 2'd2;

  // One window column: top, middle and bottom pixel.
  typedef logic [2:0][PIX_W-1:0] col_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_value;
    logic             frame_start;
  } lbp_in_t;

  typedef struct packed {
    logic [7:0] pattern_code;
    logic       binary_pixel;
    logic       frame_end;
    logic       last_of_run;
  } lbp_out_t;

  // Pattern code of the centre pixel of three columns. The neighbour weights
  // are distinct powers of two, so each compare sets one bit of the code.
  // On the bottom row the rows move up by one and the bottom is replicated.
  function automatic logic [7:0] lbp_code(input col_t lc, input col_t cc, input col_t rc,
                                          input logic bottom);
    logic [1:0]       it;
    logic [1:0]       im;
    logic [PIX_W-1:0] ctr;
    logic [7:0]       code;
    it  = bottom ? ROW_MID : ROW_TOP;
    im  = bottom ? ROW_BOT : ROW_MID;
    ctr = cc[im];
    code[7] = (cc[it] >= ctr);
    code[6] = (lc[it] >= ctr);
    code[5] = (lc[im] >= ctr);
    code[4] = (lc[ROW_BOT] >= ctr);
    code[3] = (cc[ROW_BOT] >= ctr);
    code[2] = (rc[ROW_BOT] >= ctr);
    code[1] = (rc[im] >= ctr);
    code[0] = (rc[it] >= ctr);
    return code;
  endfunction

endpackage

/* sv/lbp_3x3_with_binarize.sv */
// 3x3 local binary pattern with binarized output.
// Input channel: in_valid/in_stall with in_data carrying one grey pixel in
// raster order and a frame_start mark. A request is taken at a clock edge
// with in_valid high and in_stall low.
// Result channel: out_valid/out_stall with out_data carrying the pattern code,
// its binarized bit, frame_end on the last pixel of a frame, and last_of_run
// on the final result caused by one input pixel.
// Configuration: cfg_we/cfg_index/cfg_data write image_width, image_height
// and binarize_threshold; write them only while the block is idle.
// Results for row r-1 come out while row r streams in; the last row gives its
// own results with each of its pixels. An accepted pixel is held in the memory
// read stage, and its results go from there into the output register.
// Throughput: one pixel per clock while out_stall is low and the output
// register holds at most one result, set by the two line-store memories that
// are read at the accept edge and written back as the read stage moves on.
// A last-row pixel gives two results, the frame's last pixel up to four.
// Reset clears position, window and configuration; the line stores are not
// cleared, since every entry is written before it is read within a frame.
// When out_stall is high, the output register holds its results, one more
// pixel waits in the memory read stage, and then in_stall rises.
module lbp_3x3_with_binarize
  import lbp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  lbp_in_t          in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output lbp_out_t         out_data,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  // Configuration registers.
  logic [DIM_W-1:0] width_r;
  logic [DIM_W-1:0] height_r;
  logic [THR_W-1:0] thresh_r;

  // Clamped geometry.
  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;

  // Position of the next pixel.
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic [COL_W-1:0] col_nxt;
  logic [ROW_W-1:0] row_nxt;
  logic [COL_W-1:0] cur_c;
  logic [ROW_W-1:0] cur_r;
  logic [DIM_W-1:0] r_wide;
  logic [DIM_W-1:0] c_inc;
  logic [DIM_W-1:0] r_inc;

  // Line stores and their read data.
  logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
  logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
  logic [PIX_W-1:0] rd_u_r;
  logic [PIX_W-1:0] rd_m_r;

  // Memory read stage.
  logic             s1_valid_r;
  logic [PIX_W-1:0] s1_pix_r;
  logic [COL_W-1:0] s1_col_r;
  logic             s1_r_is0_r;
  logic             s1_r_is1_r;
  logic             s1_r_last_r;
  logic             s1_c_is1_r;
  logic             s1_c_last_r;
  logic             s1_w_is1_r;
  logic             fwd_r;
  logic [PIX_W-1:0] fwd_m_r;
  logic [PIX_W-1:0] fwd_p_r;
  logic             s1_go;
  logic             accept;

  // Window and the values computed from it.
  col_t             win_r [3];
  col_t             new_col;
  col_t             a_left;
  col_t             b_left;
  logic [PIX_W-1:0] u_eff;
  logic [PIX_W-1:0] m_eff;
  logic [7:0]       code [NSLOT];
  logic [NSLOT-1:0] slot_vld;

  // Output register with up to four results.
  lbp_out_t         s2_slot_r [NSLOT];
  logic [NSLOT-1:0] s2_vld_r;
  logic [NSLOT-1:0] s2_vld_nxt;
  logic [1:0]       sel;
  logic [NSLOT-1:0] sel_mask;
  logic             take;
  logic             last_sel;
  logic             s2_free;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      thresh_r <= THRESH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:        width_r  <= cfg_data[DIM_W-1:0];
        CFG_IMAGE_HEIGHT:       height_r <= cfg_data[DIM_W-1:0];
        CFG_BINARIZE_THRESHOLD: thresh_r <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Geometry held to its legal range.
  always_comb begin
    if (width_r == '0) begin
      w_eff = DIM_W'(1);
    end else if (width_r > DIM_W'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    if (height_r == '0) begin
      h_eff = DIM_W'(1);
    end else if (height_r > DIM_W'(MAX_HEIGHT)) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = height_r;
    end
  end

  // Position of the incoming pixel and of the one after it.
  always_comb begin
    cur_c  = in_data.frame_start ? '0 : col_r;
    r_wide = in_data.frame_start ? '0 : DIM_W'(row_r);
    if (DIM_W'(cur_c) >= w_eff) begin
      cur_c  = '0;
      r_wide = r_wide + DIM_W'(1);
    end
    if (r_wide >= h_eff) begin
      r_wide = '0;
    end
    cur_r = r_wide[ROW_W-1:0];
    c_inc = DIM_W'(cur_c) + DIM_W'(1);
    r_inc = DIM_W'(cur_r) + DIM_W'(1);
    if (c_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = (r_inc >= h_eff) ? '0 : r_inc[ROW_W-1:0];
    end else begin
      col_nxt = c_inc[COL_W-1:0];
      row_nxt = cur_r;
    end
  end

  // Handshake of the memory read stage.
  assign s1_go    = s1_valid_r && ((slot_vld == '0) || s2_free);
  assign in_stall = s1_valid_r && !s1_go;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end else begin
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
        fwd_r <= s1_go && (s1_col_r == cur_c);
      end
      s1_valid_r <= accept || (s1_valid_r && !s1_go);
    end
  end

  // Pixel and position flags carried with the read.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r    <= in_data.pixel_value;
      s1_col_r    <= cur_c;
      s1_r_is0_r  <= (cur_r == '0);
      s1_r_is1_r  <= (cur_r == ROW_W'(1));
      s1_r_last_r <= (DIM_W'(cur_r) == h_eff - DIM_W'(1));
      s1_c_is1_r  <= (cur_c == COL_W'(1));
      s1_c_last_r <= (DIM_W'(cur_c) == w_eff - DIM_W'(1));
      s1_w_is1_r  <= (w_eff == DIM_W'(1));
      fwd_m_r     <= m_eff;
      fwd_p_r     <= s1_pix_r;
    end
  end

  // Upper line store: read at accept, written with the old middle value.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_u_r <= upper_mem[cur_c];
    end
    if (s1_go) begin
      upper_mem[s1_col_r] <= m_eff;
    end
  end

  // Middle line store: read at accept, written with the new pixel.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_m_r <= middle_mem[cur_c];
    end
    if (s1_go) begin
      middle_mem[s1_col_r] <= s1_pix_r;
    end
  end

  // Read data, forwarded when the previous pixel wrote the same column.
  assign u_eff = fwd_r ? fwd_m_r : rd_u_r;
  assign m_eff = fwd_r ? fwd_p_r : rd_m_r;

  // New right column of the window, with the top border replicated.
  always_comb begin
    new_col[ROW_BOT] = s1_pix_r;
    if (s1_r_is0_r) begin
      new_col[ROW_TOP] = s1_pix_r;
      new_col[ROW_MID] = s1_pix_r;
    end else if (s1_r_is1_r) begin
      new_col[ROW_TOP] = m_eff;
      new_col[ROW_MID] = m_eff;
    end else begin
      new_col[ROW_TOP] = u_eff;
      new_col[ROW_MID] = m_eff;
    end
  end

  // Window shift.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r[0] <= '0;
      win_r[1] <= '0;
      win_r[2] <= '0;
    end else if (s1_go) begin
      win_r[0] <= win_r[1];
      win_r[1] <= win_r[2];
      win_r[2] <= new_col;
    end
  end

  // Codes for the previous column and, at the row end, the last column:
  // each for the row above and, on the last row, for the last row too.
  assign a_left = s1_c_is1_r ? win_r[2] : win_r[1];
  assign b_left = s1_w_is1_r ? new_col : win_r[2];

  always_comb begin
    code[0] = lbp_code(a_left, win_r[2], new_col, 1'b0);
    code[1] = lbp_code(a_left, win_r[2], new_col, 1'b1);
    code[2] = lbp_code(b_left, new_col, new_col, 1'b0);
    code[3] = lbp_code(b_left, new_col, new_col, 1'b1);
    slot_vld[0] = (s1_col_r != '0) && !s1_r_is0_r;
    slot_vld[1] = (s1_col_r != '0) && s1_r_last_r;
    slot_vld[2] = s1_c_last_r && !s1_r_is0_r;
    slot_vld[3] = s1_c_last_r && s1_r_last_r;
  end

  // Output selection: the lowest pending result goes first.
  always_comb begin
    sel = 2'd0;
    for (int i = NSLOT - 1; i >= 0; i--) begin
      if (s2_vld_r[i]) begin
        sel = 2'(i);
      end
    end
    sel_mask = NSLOT'(1) << sel;
    last_sel = ((s2_vld_r & ~sel_mask) == '0);
  end

  assign out_valid = (s2_vld_r != '0);
  assign take      = out_valid && !out_stall;
  assign s2_free   = (s2_vld_r == '0) || (take && last_sel);

  always_comb begin
    out_data             = s2_slot_r[sel];
    out_data.last_of_run = last_sel;
  end

  // Output register valid bits.
  always_comb begin
    s2_vld_nxt = s2_vld_r;
    if (take) begin
      s2_vld_nxt = s2_vld_r & ~sel_mask;
    end
    if (s1_go && (slot_vld != '0)) begin
      s2_vld_nxt = slot_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= '0;
    end else begin
      s2_vld_r <= s2_vld_nxt;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (s1_go && (slot_vld != '0)) begin
      for (int i = 0; i < NSLOT; i++) begin
        s2_slot_r[i].pattern_code <= code[i];
        s2_slot_r[i].binary_pixel <= (code[i] >= thresh_r);
        s2_slot_r[i].frame_end    <= (i == NSLOT - 1);
        s2_slot_r[i].last_of_run  <= 1'b0;
      end
    end
  end

endmodule
